// ===== hw/rtl/mpu_pkg.sv =====
// ----------------------------------------------------------------------------
// mpu_pkg: shared types and constants of the multiset permutation unranker
// Opcodes, status codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mpu_pkg;

  // number of desired-count registers and width of counts
  localparam int NREG   = 4;
  localparam int KIW    = 2;
  localparam int KPW    = 3;
  localparam int CNTW   = 5;
  // rank and multinomial widths, product of multinomial and a count
  localparam int IDXW   = 45;
  localparam int MW     = 62;
  localparam int PW     = MW + CNTW;
  localparam int CFG_IW = 8;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_UNRANK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_POS  = 3'd1,
    ST_NO_KIND  = 3'd2,
    ST_OVERUSED = 3'd3,
    ST_RANGE    = 3'd4,
    ST_UNSET    = 3'd5,
    ST_BAD_CFG  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    EM_OP,
    EM_UR_SINGLE,
    EM_UR_SLOT
  } emit_e;

  typedef struct packed {
    logic  take_in;
    logic  scan_init;
    logic  scan_sub;
    logic  scan_step;
    logic  apply;
    logic  mb_init;
    logic  mb_next_kind;
    logic  mul_build;
    logic  mul_block;
    logic  div_start;
    logic  div_by_t;
    logic  mb_commit;
    logic  ur_init;
    logic  ur_next_kind;
    logic  ur_choose;
    logic  ur_reject;
    logic  ur_next_slot;
    logic  emit_load;
    emit_e emit_mode;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic pos_ok;
    logic pool_ok;
    logic ptr_end;
    logic cur_valid;
    logic kp_end;
    logic rem_zero;
    logic i_end;
    logic div_busy;
    logic idx_lt_block;
    logic idx_ge_comb;
    logic none_empty;
    logic res_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mpu_div.sv =====
// ----------------------------------------------------------------------------
// mpu_div: radix-2 restoring divider
// Divides a product by a small count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpu_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mpu_pkg::PW-1:0]   dividend_i,
  input  logic [mpu_pkg::CNTW-1:0] divisor_i,
  output logic                     busy_o,
  output logic [mpu_pkg::PW-1:0]   quot_o
);

  localparam int NW = $clog2(mpu_pkg::PW + 1);

  logic                     busy_q;
  logic [NW-1:0]            cnt_q;
  logic [mpu_pkg::PW-1:0]   q_q;
  logic [mpu_pkg::CNTW-1:0] r_q;
  logic [mpu_pkg::CNTW-1:0] d_q;
  logic [mpu_pkg::CNTW:0]   trial;
  logic                     ge;
  logic [mpu_pkg::CNTW-1:0] r_next;

  // one restoring step
  always_comb begin
    trial  = {r_q, q_q[mpu_pkg::PW-1]};
    ge     = trial >= {1'b0, d_q};
    r_next = ge ? mpu_pkg::CNTW'(trial - {1'b0, d_q}) : trial[mpu_pkg::CNTW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(mpu_pkg::PW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[mpu_pkg::PW-2:0], ge};
      r_q <= r_next;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

// ===== hw/rtl/mpu_datapath.sv =====
// ----------------------------------------------------------------------------
// mpu_datapath: slot row, pool counters, multinomial arithmetic, result reg
// Executes the commands of the controller and reports its status back.
// ----------------------------------------------------------------------------
module mpu_datapath #(
  parameter int SLOTS = 16,
  parameter int KINDS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpu_pkg::dp_cmd_t           cmd_i,
  output mpu_pkg::dp_stat_t          stat_o,
  input  logic [1:0]                 op_i,
  input  logic [3:0]                 pos_i,
  input  logic [1:0]                 kind_i,
  input  logic [mpu_pkg::IDXW-1:0]   idx_i,
  input  logic                       cfg_we_i,
  input  logic [mpu_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [mpu_pkg::CNTW-1:0]   cfg_data_i,
  output logic [2:0]                 res_status_o,
  output logic [3:0]                 res_slot_o,
  output logic [1:0]                 res_kind_o,
  output logic                       res_set_o,
  output logic [mpu_pkg::CNTW-1:0]   res_asg_o,
  output logic [mpu_pkg::IDXW-1:0]   res_comb_o,
  output logic                       res_last_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KN = (KINDS < mpu_pkg::NREG) ? KINDS : mpu_pkg::NREG;

  // configuration and slot row
  logic [mpu_pkg::CNTW-1:0] desired_q [mpu_pkg::NREG];
  logic [SLOTS-1:0]         valid_q;
  logic [1:0]               kind_q [SLOTS];

  // latched item
  mpu_pkg::op_e             op_q;
  logic [3:0]               pos_q;
  logic [1:0]               kin_q;
  logic [mpu_pkg::IDXW-1:0] idx_q;

  // scan and arithmetic state
  logic [CW-1:0]            ptr_q;
  logic [mpu_pkg::CNTW-1:0] rem_q [mpu_pkg::NREG];
  mpu_pkg::status_e         pst_q;
  mpu_pkg::status_e         st_q;
  logic [mpu_pkg::CNTW-1:0] asg_q;
  logic                     cap_set_q;
  logic [1:0]               cap_kind_q;
  logic [mpu_pkg::MW-1:0]   m_q;
  logic [mpu_pkg::MW-1:0]   comb_q;
  logic [mpu_pkg::CNTW-1:0] t_q;
  logic [mpu_pkg::CNTW-1:0] i_q;
  logic [mpu_pkg::KPW-1:0]  kp_q;
  logic [mpu_pkg::PW-1:0]   prod_q;

  // result register
  mpu_pkg::status_e         res_status_q;
  logic [3:0]               res_slot_q;
  logic [1:0]               res_kind_q;
  logic                     res_set_q;
  logic [mpu_pkg::CNTW-1:0] res_asg_q;
  logic [mpu_pkg::IDXW-1:0] res_comb_q;
  logic                     res_last_q;

  logic [SW-1:0]            a;
  logic [SW-1:0]            pa;
  logic                     pos_ok;
  logic                     pos_in_ok;
  logic                     v;
  logic [1:0]               kd;
  logic                     kind_bad;
  logic [6:0]               sum_d;
  logic [mpu_pkg::CNTW-1:0] rem_kp;
  logic [mpu_pkg::CNTW-1:0] mul_op;
  logic [mpu_pkg::PW-1:0]   prod_d;
  logic                     div_busy;
  logic [mpu_pkg::PW-1:0]   quot;
  logic [mpu_pkg::MW-1:0]   blk;
  logic                     pool_ok;
  logic                     idx_ge_comb;
  logic [mpu_pkg::MW-1:0]   sat_src;
  logic [mpu_pkg::IDXW-1:0] sat;
  mpu_pkg::status_e         e_status;
  logic [3:0]               e_slot;
  logic [1:0]               e_kind;
  logic                     e_set;
  logic [mpu_pkg::IDXW-1:0] e_comb;
  logic                     e_last;

  // slot under the scan pointer, with the pending set substituted
  always_comb begin
    a         = ptr_q[SW-1:0];
    pa        = SW'(pos_q);
    pos_ok    = 5'(pos_q) < 5'(SLOTS);
    pos_in_ok = 5'(pos_i) < 5'(SLOTS);
    if (cmd_i.scan_sub && a == pa) begin
      v  = 1'b1;
      kd = kin_q;
    end else begin
      v  = valid_q[a];
      kd = kind_q[a];
    end
    kind_bad = ({1'b0, kd} >= mpu_pkg::KPW'(KN)) || (desired_q[kd] == '0);
  end

  // sum of the desired counts of the active kinds
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < KN; k++) begin
      sum_d = sum_d + 7'(desired_q[k]);
    end
  end

  // multiply operand and shared divider
  always_comb begin
    rem_kp = rem_q[kp_q[mpu_pkg::KIW-1:0]];
    mul_op = cmd_i.mul_block ? rem_kp : t_q + mpu_pkg::CNTW'(1);
    prod_d = mpu_pkg::PW'(m_q) * mpu_pkg::PW'(mul_op);
  end

  mpu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (cmd_i.div_by_t ? t_q : i_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign blk         = quot[mpu_pkg::MW-1:0];
  assign pool_ok     = pst_q == mpu_pkg::ST_OK;
  assign idx_ge_comb = mpu_pkg::MW'(idx_q) >= m_q;

  // result fields
  always_comb begin
    sat_src  = (cmd_i.emit_mode == mpu_pkg::EM_UR_SLOT) ? comb_q : m_q;
    sat      = (|sat_src[mpu_pkg::MW-1:mpu_pkg::IDXW]) ? '1 : sat_src[mpu_pkg::IDXW-1:0];
    e_status = mpu_pkg::ST_OK;
    e_slot   = '0;
    e_kind   = '0;
    e_set    = 1'b0;
    e_comb   = '0;
    e_last   = 1'b1;
    case (cmd_i.emit_mode)
      mpu_pkg::EM_OP: begin
        if (op_q == mpu_pkg::OP_READ && st_q == mpu_pkg::ST_OK && !cap_set_q) begin
          e_status = mpu_pkg::ST_UNSET;
        end else begin
          e_status = st_q;
        end
        e_slot = pos_q;
        e_kind = cap_set_q ? cap_kind_q : 2'd0;
        e_set  = cap_set_q;
        e_comb = pool_ok ? sat : '0;
      end
      mpu_pkg::EM_UR_SINGLE: begin
        if (!pool_ok) begin
          e_status = pst_q;
        end else if (idx_ge_comb) begin
          e_status = mpu_pkg::ST_RANGE;
        end
        e_comb = (pool_ok && !idx_ge_comb) ? sat : '0;
      end
      mpu_pkg::EM_UR_SLOT: begin
        e_slot = 4'(ptr_q);
        e_kind = (kp_q == mpu_pkg::KPW'(KN)) ? 2'd0 : kp_q[mpu_pkg::KIW-1:0];
        e_comb = sat;
        e_last = t_q == mpu_pkg::CNTW'(1);
      end
      default: begin
        e_last = 1'b1;
      end
    endcase
  end

  // configuration registers and slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int k = 0; k < mpu_pkg::NREG; k++) begin
        desired_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i && cfg_index_i < mpu_pkg::CFG_IW'(mpu_pkg::NREG)) begin
        desired_q[cfg_index_i[mpu_pkg::KIW-1:0]] <= cfg_data_i;
      end
      if (cmd_i.apply && pos_ok) begin
        if (op_q == mpu_pkg::OP_SET && pool_ok) begin
          valid_q[pa] <= 1'b1;
        end else if (op_q == mpu_pkg::OP_CLEAR) begin
          valid_q[pa] <= 1'b0;
        end
      end
    end
  end

  // slot kinds
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && pos_ok && op_q == mpu_pkg::OP_SET && pool_ok) begin
      kind_q[pa] <= kin_q;
    end
  end

  // item, scan and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q  <= mpu_pkg::op_e'(op_i);
      pos_q <= pos_i;
      kin_q <= kind_i;
      idx_q <= idx_i;
      st_q  <= pos_in_ok ? mpu_pkg::ST_OK : mpu_pkg::ST_BAD_POS;
    end
    if (cmd_i.apply && pos_ok && op_q == mpu_pkg::OP_SET) begin
      st_q <= pst_q;
    end

    // pool scan
    if (cmd_i.scan_init) begin
      ptr_q      <= '0;
      asg_q      <= '0;
      cap_set_q  <= 1'b0;
      cap_kind_q <= '0;
      pst_q      <= (sum_d == 7'(SLOTS)) ? mpu_pkg::ST_OK : mpu_pkg::ST_BAD_CFG;
      for (int k = 0; k < mpu_pkg::NREG; k++) begin
        rem_q[k] <= (k < KN) ? desired_q[k] : '0;
      end
    end
    if (cmd_i.scan_step) begin
      ptr_q <= ptr_q + CW'(1);
      asg_q <= asg_q + mpu_pkg::CNTW'(valid_q[a]);
      if (6'(ptr_q) == 6'(pos_q)) begin
        cap_set_q  <= valid_q[a];
        cap_kind_q <= kind_q[a];
      end
      if (pool_ok && v) begin
        if (kind_bad) begin
          pst_q <= mpu_pkg::ST_NO_KIND;
        end else if (rem_q[kd] == '0) begin
          pst_q <= mpu_pkg::ST_OVERUSED;
        end else begin
          rem_q[kd] <= rem_q[kd] - mpu_pkg::CNTW'(1);
        end
      end
    end

    // multinomial build
    if (cmd_i.mb_init) begin
      m_q  <= mpu_pkg::MW'(1);
      t_q  <= '0;
      kp_q <= '0;
      i_q  <= mpu_pkg::CNTW'(1);
    end
    if (cmd_i.mb_next_kind) begin
      kp_q <= kp_q + mpu_pkg::KPW'(1);
      i_q  <= mpu_pkg::CNTW'(1);
    end
    if (cmd_i.mul_build || cmd_i.mul_block) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mb_commit) begin
      m_q <= blk;
      t_q <= t_q + mpu_pkg::CNTW'(1);
      i_q <= i_q + mpu_pkg::CNTW'(1);
    end

    // unrank walk
    if (cmd_i.ur_init) begin
      comb_q <= m_q;
      ptr_q  <= '0;
      kp_q   <= '0;
    end
    if (cmd_i.ur_next_kind) begin
      kp_q <= kp_q + mpu_pkg::KPW'(1);
    end
    if (cmd_i.ur_reject) begin
      idx_q <= idx_q - blk[mpu_pkg::IDXW-1:0];
      kp_q  <= kp_q + mpu_pkg::KPW'(1);
    end
    if (cmd_i.ur_choose) begin
      rem_q[kp_q[mpu_pkg::KIW-1:0]] <= rem_kp - mpu_pkg::CNTW'(1);
      t_q <= t_q - mpu_pkg::CNTW'(1);
      m_q <= blk;
    end
    if (cmd_i.ur_next_slot) begin
      ptr_q <= ptr_q + CW'(1);
      kp_q  <= '0;
    end

    // result beat
    if (cmd_i.emit_load) begin
      res_status_q <= e_status;
      res_slot_q   <= e_slot;
      res_kind_q   <= e_kind;
      res_set_q    <= e_set;
      res_asg_q    <= asg_q;
      res_comb_q   <= e_comb;
      res_last_q   <= e_last;
    end
  end

  // status to the controller
  always_comb begin
    stat_o.op           = op_q;
    stat_o.pos_ok       = pos_ok;
    stat_o.pool_ok      = pool_ok;
    stat_o.ptr_end      = ptr_q == CW'(SLOTS);
    stat_o.cur_valid    = valid_q[a];
    stat_o.kp_end       = kp_q == mpu_pkg::KPW'(KN);
    stat_o.rem_zero     = rem_kp == '0;
    stat_o.i_end        = i_q > rem_kp;
    stat_o.div_busy     = div_busy;
    stat_o.idx_lt_block = mpu_pkg::MW'(idx_q) < blk;
    stat_o.idx_ge_comb  = idx_ge_comb;
    stat_o.none_empty   = t_q == '0;
    stat_o.res_last     = res_last_q;
  end

  assign res_status_o = res_status_q;
  assign res_slot_o   = res_slot_q;
  assign res_kind_o   = res_kind_q;
  assign res_set_o    = res_set_q;
  assign res_asg_o    = res_asg_q;
  assign res_comb_o   = res_comb_q;
  assign res_last_o   = res_last_q;

endmodule

// ===== hw/rtl/mpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpu_ctrl: sequencer of the multiset permutation unranker
// Steps pool scans, multinomial build, unrank walk and result beats.
// ----------------------------------------------------------------------------
module mpu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mpu_pkg::dp_stat_t  stat_i,
  output mpu_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_SCAN1,
    S_SCAN,
    S_MB,
    S_MB_DIVS,
    S_MB_DIV,
    S_FIN,
    S_UR_SLOT,
    S_UR_KIND,
    S_UR_DIVS,
    S_UR_DIV,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.scan_init = 1'b1;
        if (stat_i.op == mpu_pkg::OP_SET && stat_i.pos_ok) begin
          state_d = S_SCAN1;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN1: begin
        if (stat_i.ptr_end) begin
          cmd_o.apply     = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.scan_sub  = 1'b1;
        end
      end
      S_SCAN: begin
        if (!stat_i.ptr_end) begin
          cmd_o.scan_step = 1'b1;
        end else if (stat_i.pool_ok) begin
          cmd_o.mb_init = 1'b1;
          state_d       = S_MB;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MB: begin
        if (stat_i.kp_end) begin
          state_d = S_FIN;
        end else if (stat_i.i_end) begin
          cmd_o.mb_next_kind = 1'b1;
        end else begin
          cmd_o.mul_build = 1'b1;
          state_d         = S_MB_DIVS;
        end
      end
      S_MB_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MB_DIV;
      end
      S_MB_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.mb_commit = 1'b1;
          state_d         = S_MB;
        end
      end
      S_FIN: begin
        if (stat_i.op != mpu_pkg::OP_UNRANK) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_mode = mpu_pkg::EM_OP;
          state_d         = S_EMIT;
        end else if (!stat_i.pool_ok || stat_i.idx_ge_comb || stat_i.none_empty) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_mode = mpu_pkg::EM_UR_SINGLE;
          state_d         = S_EMIT;
        end else begin
          cmd_o.ur_init = 1'b1;
          state_d       = S_UR_SLOT;
        end
      end
      S_UR_SLOT: begin
        if (stat_i.ptr_end) begin
          state_d = S_IDLE;
        end else if (stat_i.cur_valid) begin
          cmd_o.ur_next_slot = 1'b1;
        end else begin
          state_d = S_UR_KIND;
        end
      end
      S_UR_KIND: begin
        if (stat_i.kp_end) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_mode = mpu_pkg::EM_UR_SLOT;
          state_d         = S_EMIT;
        end else if (stat_i.rem_zero) begin
          cmd_o.ur_next_kind = 1'b1;
        end else begin
          cmd_o.mul_block = 1'b1;
          state_d         = S_UR_DIVS;
        end
      end
      S_UR_DIVS: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_by_t  = 1'b1;
        state_d         = S_UR_DIV;
      end
      S_UR_DIV: begin
        if (!stat_i.div_busy) begin
          if (stat_i.idx_lt_block) begin
            cmd_o.ur_choose = 1'b1;
            cmd_o.emit_load = 1'b1;
            cmd_o.emit_mode = mpu_pkg::EM_UR_SLOT;
            state_d         = S_EMIT;
          end else begin
            cmd_o.ur_reject = 1'b1;
            state_d         = S_UR_KIND;
          end
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (stat_i.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ur_next_slot = 1'b1;
            state_d            = S_UR_SLOT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= state_d == S_EMIT;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result beat is pending");

  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_busy |-> (state_q == S_MB_DIV || state_q == S_UR_DIV))
    else $error("divider busy outside a wait state");

  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_ready_i && !stat_i.res_last) |=> state_q == S_UR_SLOT)
    else $error("item ended before its last beat");
`endif

endmodule

// ===== hw/rtl/multiset_permutation_unranker.sv =====
// ----------------------------------------------------------------------------
// multiset_permutation_unranker: slot row with multinomial unranking
// Keeps a row of slots checked against a pool of desired counts per kind.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_axis channel (set, clear, read or unrank),
// results leave on m_axis, one beat per set, clear or read, and one beat per
// empty slot for unrank (a single beat on error or a full row); tlast marks
// the final beat of an item. Desired counts are written on the cfg channel,
// which is always ready; write it only while the block is idle.
// One item is worked on at a time: s_axis_tready is high only when idle.
// Each pool scan walks the row one slot per cycle (a set scans twice).
// On a consistent row the multinomial count is then built with one multiply
// and a radix-2 divide per empty slot. Unrank then runs a multiply and a
// divide on the same divider per kind tried for every empty slot.
// A stalled m_axis beat holds the sequencer in place until taken.
// Reset empties all slots and clears the desired counts to zero.
// ----------------------------------------------------------------------------
module multiset_permutation_unranker #(
  parameter int SLOTS = 16,
  parameter int KINDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // op[1:0], position[5:2], kind[7:6], rank[52:8]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,
  // status[2:0], slot[6:3], slot_kind_out[8:7], slot_is_set[9],
  // assigned_count[14:10], combinations[59:15]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mpu_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [mpu_pkg::CNTW-1:0]   cfg_data_i
);

  mpu_pkg::dp_cmd_t         cmd;
  mpu_pkg::dp_stat_t        stat;
  logic [2:0]               res_status;
  logic [3:0]               res_slot;
  logic [1:0]               res_kind;
  logic                     res_set;
  logic [mpu_pkg::CNTW-1:0] res_asg;
  logic [mpu_pkg::IDXW-1:0] res_comb;

  assign cfg_ready_o = 1'b1;

  mpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mpu_datapath #(
    .SLOTS (SLOTS),
    .KINDS (KINDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (s_axis_tdata_i[1:0]),
    .pos_i        (s_axis_tdata_i[5:2]),
    .kind_i       (s_axis_tdata_i[7:6]),
    .idx_i        (s_axis_tdata_i[52:8]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_status_o (res_status),
    .res_slot_o   (res_slot),
    .res_kind_o   (res_kind),
    .res_set_o    (res_set),
    .res_asg_o    (res_asg),
    .res_comb_o   (res_comb),
    .res_last_o   (m_axis_tlast_o)
  );

  // result beat packing
  assign m_axis_tdata_o = {4'b0, res_comb, res_asg, res_set, res_kind, res_slot, res_status};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the multiset permutation unranker
// Drives set, clear, read and unrank items under several pools of desired
// counts, predicts every result beat from a model of the slot row, and
// compares each beat field by field while both streams idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          NSLOT     = 16;
  localparam int          NKIND     = 4;
  localparam int          CYC_LIMIT = 15_000_000;
  localparam logic [63:0] CAP45     = (64'd1 << 45) - 64'd1;

  typedef int unsigned pool_t [mpu_pkg::NREG];

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [1:0]  kind;
    logic        is_set;
    logic [4:0]  assigned;
    logic [44:0] comb;
    logic        last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [mpu_pkg::CFG_IW-1:0] cfg_index_i = '0;
  logic [mpu_pkg::CNTW-1:0]   cfg_data_i = '0;

  // model state of the row and the pool
  logic [4:0] want_cnt [mpu_pkg::NREG];
  logic       row_valid [NSLOT];
  logic [1:0] row_kind [NSLOT];

  beat_t      pending_beats [$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;
  int         ready_gap = 0;

  multiset_permutation_unranker #(
    .SLOTS(NSLOT),
    .KINDS(NKIND)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result-side stalls in bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_gap <= $urandom_range(0, 3);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // pool scan: status of the row with slot sub taken as holding subkind
  function automatic logic [2:0] scan_pool(int sub, logic [1:0] subkind,
                                           output pool_t left);
    int unsigned sum;
    logic        v;
    logic [1:0]  kd;
    sum = 0;
    for (int k = 0; k < mpu_pkg::NREG; k++) begin
      left[k] = (k < NKIND) ? int'(want_cnt[k]) : 0;
      sum += left[k];
    end
    if (sum != NSLOT) return mpu_pkg::ST_BAD_CFG;
    for (int i = 0; i < NSLOT; i++) begin
      v  = (i == sub) ? 1'b1 : row_valid[i];
      kd = (i == sub) ? subkind : row_kind[i];
      if (!v) continue;
      if (kd >= NKIND || want_cnt[kd] == 0) return mpu_pkg::ST_NO_KIND;
      if (left[kd] == 0) return mpu_pkg::ST_OVERUSED;
      left[kd]--;
    end
    return mpu_pkg::ST_OK;
  endfunction

  function automatic logic [63:0] fillings(pool_t left);
    logic [63:0] r;
    logic [63:0] total;
    r = 1;
    total = 0;
    for (int k = 0; k < mpu_pkg::NREG; k++) begin
      for (int i = 1; i <= left[k]; i++) begin
        total++;
        r = r * total / i;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] filled_count();
    logic [4:0] n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += 5'(row_valid[i]);
    return n;
  endfunction

  function automatic logic [44:0] sat45(logic [63:0] v);
    return (v > CAP45) ? CAP45[44:0] : v[44:0];
  endfunction

  task automatic push_beat(logic [2:0] st, logic [3:0] sl, logic [1:0] kd,
                           logic is_set, logic [4:0] asg, logic [63:0] cb);
    beat_t b;
    b.status = st; b.slot = sl; b.kind = kd; b.is_set = is_set;
    b.assigned = asg; b.comb = sat45(cb); b.last = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // predict the beats of one item and update the model row
  task automatic predict_item(mpu_pkg::op_e op, logic [3:0] pos, logic [1:0] kind,
                              logic [44:0] rank);
    pool_t       left;
    logic [2:0]  st;
    logic [4:0]  asg;
    logic [63:0] total;
    logic [63:0] idx;
    logic [63:0] blk;
    logic [1:0]  pick;
    int          n;
    n = 0;
    total = 0;
    idx = 64'(rank);
    if (op == mpu_pkg::OP_UNRANK) begin
      st = scan_pool(-1, 2'd0, left);
      asg = filled_count();
      if (st == mpu_pkg::ST_OK) begin
        total = fillings(left);
        if (idx >= total) st = mpu_pkg::ST_RANGE;
      end
      if (st == mpu_pkg::ST_OK) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (row_valid[i]) continue;
          pick = 0;
          for (int k = 0; k < mpu_pkg::NREG && k < NKIND; k++) begin
            if (left[k] == 0) continue;
            left[k]--;
            blk = fillings(left);
            if (idx < blk) begin
              pick = k[1:0];
              break;
            end
            idx -= blk;
            left[k]++;
          end
          push_beat(mpu_pkg::ST_OK, 4'(i), pick, 1'b0, asg, total);
          n++;
        end
      end
      if (n == 0) begin
        push_beat(st, 4'd0, 2'd0, 1'b0, asg,
                  (st == mpu_pkg::ST_OK) ? total : 64'd0);
      end
    end else begin
      st = mpu_pkg::ST_OK;
      if (op == mpu_pkg::OP_SET) begin
        st = scan_pool(int'(pos), kind, left);
        if (st == mpu_pkg::ST_OK) begin
          row_valid[pos] = 1'b1;
          row_kind[pos] = kind;
        end
      end else if (op == mpu_pkg::OP_CLEAR) begin
        row_valid[pos] = 1'b0;
      end else if (!row_valid[pos]) begin
        st = mpu_pkg::ST_UNSET;
      end
      asg = filled_count();
      if (scan_pool(-1, 2'd0, left) == mpu_pkg::ST_OK) total = fillings(left);
      push_beat(st, pos, row_valid[pos] ? row_kind[pos] : 2'd0, row_valid[pos], asg,
                total);
    end
    pending_beats[pending_beats.size() - 1].last = 1'b1;
  endtask

  // send one item beat; valid is lowered at the accepting edge
  task automatic send_item(mpu_pkg::op_e op, logic [3:0] pos, logic [1:0] kind,
                           logic [44:0] rank);
    @(posedge clk_i);
    if (!quiet && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    predict_item(op, pos, kind, rank);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'b000, rank, kind, pos, op};
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_count(logic [mpu_pkg::CFG_IW-1:0] idx,
                             logic [mpu_pkg::CNTW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < mpu_pkg::NREG) want_cnt[idx[1:0]] = val;
  endtask

  task automatic load_pool(int c0, int c1, int c2, int c3);
    wait_drained();
    write_count(8'd0, 5'(c0));
    write_count(8'd1, 5'(c1));
    write_count(8'd2, 5'(c2));
    write_count(8'd3, 5'(c3));
  endtask

  // fillings of the current row, zero when inconsistent
  function automatic logic [63:0] row_fillings();
    pool_t left;
    if (scan_pool(-1, 2'd0, left) != mpu_pkg::ST_OK) return 0;
    return fillings(left);
  endfunction

  function automatic logic [44:0] rand45();
    return 45'({$urandom, $urandom});
  endfunction

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata_o);
      end else begin
        b = pending_beats.pop_front();
        if (m_axis_tdata_o[2:0] !== b.status || m_axis_tdata_o[6:3] !== b.slot ||
            m_axis_tdata_o[8:7] !== b.kind || m_axis_tdata_o[9] !== b.is_set ||
            m_axis_tdata_o[14:10] !== b.assigned || m_axis_tdata_o[59:15] !== b.comb ||
            m_axis_tlast_o !== b.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d slot=%0d kind=%0d set=%0d asg=%0d comb=%0d last=%0d",
                     b.status, b.slot, b.kind, b.is_set, b.assigned, b.comb, b.last);
            $display("          got st=%0d slot=%0d kind=%0d set=%0d asg=%0d comb=%0d last=%0d",
                     m_axis_tdata_o[2:0], m_axis_tdata_o[6:3], m_axis_tdata_o[8:7],
                     m_axis_tdata_o[9], m_axis_tdata_o[14:10], m_axis_tdata_o[59:15],
                     m_axis_tlast_o);
          end
        end
      end
    end
  end

  // reads, a set, an unrank and a clear before any pool is loaded
  task automatic test_reset_state();
    send_item(mpu_pkg::OP_READ, 4'd0, 2'd0, '0);
    send_item(mpu_pkg::OP_READ, 4'd15, 2'd0, '0);
    send_item(mpu_pkg::OP_SET, 4'd3, 2'd1, '0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, '0);
    send_item(mpu_pkg::OP_CLEAR, 4'd9, 2'd0, '0);
  endtask

  // single-kind pool, absent kind, overuse, range errors, full row
  task automatic test_directed();
    load_pool(16, 0, 0, 0);
    send_item(mpu_pkg::OP_SET, 4'd0, 2'd1, '0);
    send_item(mpu_pkg::OP_SET, 4'd15, 2'd0, '0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd1);
    load_pool(1, 15, 0, 0);
    write_count(8'd4, 5'd31);
    write_count(8'hff, 5'd7);
    send_item(mpu_pkg::OP_SET, 4'd1, 2'd0, '0);
    send_item(mpu_pkg::OP_CLEAR, 4'd15, 2'd0, '0);
    send_item(mpu_pkg::OP_SET, 4'd1, 2'd0, '0);
    send_item(mpu_pkg::OP_SET, 4'd2, 2'd0, '0);
    send_item(mpu_pkg::OP_SET, 4'd2, 2'd3, '0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd14);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd15);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, {45{1'b1}});
    load_pool(4, 4, 4, 4);
    send_item(mpu_pkg::OP_CLEAR, 4'd1, 2'd0, '0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd63062999);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd0);
    for (int i = 0; i < NSLOT; i++) send_item(mpu_pkg::OP_SET, 4'(i), i[1:0], '0);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, 45'd0);
    send_item(mpu_pkg::OP_READ, 4'd7, 2'd0, '0);
    load_pool(16, 16, 16, 16);
    send_item(mpu_pkg::OP_UNRANK, 4'd0, 2'd0, '0);
    send_item(mpu_pkg::OP_READ, 4'd5, 2'd0, '0);
  endtask

  // random pools and mostly well-formed fill and unrank sequences
  task automatic test_random_fill();
    int          c [mpu_pkg::NREG];
    int          r;
    int          k;
    int          spare;
    logic [3:0]  pos;
    logic [63:0] tot;
    pool_t       left;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) quiet = 1'b1;
      wait_drained();
      for (int i = 0; i < NSLOT; i++) send_item(mpu_pkg::OP_CLEAR, 4'(i), 2'd0, '0);
      if ($urandom_range(0, 6) == 0) begin
        for (int j = 0; j < mpu_pkg::NREG; j++) c[j] = $urandom_range(0, 16);
      end else begin
        spare = NSLOT;
        for (int j = 0; j < mpu_pkg::NREG - 1; j++) begin
          c[j] = $urandom_range(0, spare);
          spare -= c[j];
        end
        c[mpu_pkg::NREG - 1] = spare;
        k = $urandom_range(0, mpu_pkg::NREG - 1);
        for (int j = 0; j < k; j++) begin
          spare = c[0]; c[0] = c[1]; c[1] = c[2]; c[2] = c[3]; c[3] = spare;
        end
      end
      load_pool(c[0], c[1], c[2], c[3]);
      for (int n = 0; n < 27; n++) begin
        r = $urandom_range(0, 99);
        pos = 4'($urandom_range(0, NSLOT - 1));
        if (r < 45) begin
          k = $urandom_range(0, NKIND - 1);
          if (scan_pool(-1, 2'd0, left) == mpu_pkg::ST_OK && $urandom_range(0, 6) != 0) begin
            for (int t = 0; t < NKIND && left[k] == 0; t++) k = (k + 1) % NKIND;
            for (int t = 0; t < NSLOT && row_valid[pos]; t++) pos = pos + 4'd1;
          end
          send_item(mpu_pkg::OP_SET, pos, 2'(k), rand45());
        end else if (r < 62) begin
          tot = row_fillings();
          if (tot != 0 && $urandom_range(0, 9) != 0)
            send_item(mpu_pkg::OP_UNRANK, pos, 2'($urandom),
                      45'({$urandom, $urandom} % tot));
          else
            send_item(mpu_pkg::OP_UNRANK, pos, 2'($urandom), rand45());
        end else if (r < 77) begin
          send_item(mpu_pkg::OP_READ, pos, 2'($urandom), rand45());
        end else if (r < 90) begin
          send_item(mpu_pkg::OP_CLEAR, pos, 2'($urandom), rand45());
        end else begin
          send_item(mpu_pkg::OP_SET, pos, 2'($urandom), rand45());
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      row_valid[i] = 1'b0;
      row_kind[i] = 2'd0;
    end
    for (int k = 0; k < mpu_pkg::NREG; k++) want_cnt[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed();
    test_random_fill();
    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
